>>> sv/tmh_pkg.sv
// ----------------------------------------------------------------------------
// Timer min-heap package
// Shared types and codes for the timer heap unit.
// ----------------------------------------------------------------------------
package tmh_pkg;

   localparam int ID_W     = 6;
   localparam int TIME_W   = 32;
   localparam int CNT_W    = 7;
   localparam int ST_W     = 3;
   localparam int ID_COUNT = 64;
   localparam int RB_AW    = 6;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_REMOVE = 3'd1;
   localparam logic [2:0] KIND_ADJUST = 3'd2;
   localparam logic [2:0] KIND_POP    = 3'd3;
   localparam logic [2:0] KIND_TICK   = 3'd4;

   localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
   localparam logic [ST_W-1:0] ST_EXPIRED = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
   localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
   localparam logic [ST_W-1:0] ST_NONE    = 3'd4;
   localparam logic [ST_W-1:0] ST_DUP     = 3'd5;

   typedef struct packed {
      logic [ID_W-1:0]   owner;
      logic [TIME_W-1:0] expiry;
   } entry_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] expiry;
   } rec_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOKUP,
      S_TAKE,
      S_TICK_CHK,
      S_TICK_EVAL,
      S_TICK_END,
      S_UP,
      S_UP_CMP,
      S_DN,
      S_DN_CMP,
      S_PLACE,
      S_FIN_RD,
      S_FIN,
      S_OUT_RD,
      S_OUT
   } state_type;

endpackage

>>> sv/tmh_heap_ram.sv
// ----------------------------------------------------------------------------
// Timer heap storage
// One write port and two registered read ports over the heap slots.
// ----------------------------------------------------------------------------
module tmh_heap_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tmh_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr_a,
   output tmh_pkg::entry_type  rd_data_a,
   input  logic [AW-1:0]       rd_addr_b,
   output tmh_pkg::entry_type  rd_data_b
);

   tmh_pkg::entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

>>> sv/timer_min_heap_unit.sv
// ----------------------------------------------------------------------------
// Timer min-heap unit
// Binary min-heap of timers keyed by expiry, with an id to slot map.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; req_tready is high only when idle, and the unit
// returns to idle only after the last response of a request is accepted, so the next
// request waits for the whole sequence, which grows with each level sifted and, for a
// tick, with each expired timer.
// Reset: heap empty and all ids marked absent at once through per-id valid bits.
module timer_min_heap_unit #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // kind
   input  logic [71:0] req_tdata,   // timer_id, expire_time, now_time, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast,
   output logic [79:0] rsp_tdata    // out_timer_id, out_expire, count, top_valid,
                                    // top_expire, zero pad
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = IW + 2;

   tmh_pkg::state_type state_ff, state_in;
   logic [2:0]                  kind_ff, kind_in;
   logic [tmh_pkg::ID_W-1:0]    id_ff, id_in;
   logic [tmh_pkg::TIME_W-1:0]  exp_ff, exp_in, now_ff, now_in, top_ff, top_in;
   logic [tmh_pkg::CNT_W-1:0]   count_ff, count_in, n_ff, n_in, o_ff, o_in;
   logic [IW-1:0]               hole_ff, hole_in, loc_ff, loc_in;
   tmh_pkg::entry_type          cur_ff, cur_in;

   logic                        hw_en;
   logic [IW-1:0]               hw_addr, ra_addr, rb_addr;
   tmh_pkg::entry_type          hw_data, ra_data, rb_data;

   logic [IW-1:0]               slot_mem [tmh_pkg::ID_COUNT];
   logic [tmh_pkg::ID_COUNT-1:0] valid_ff;
   logic [IW-1:0]               slot_q_ff;
   logic                        valid_q_ff;
   logic                        sw_en, sv_en, sc_en;
   logic [tmh_pkg::ID_W-1:0]    sw_id, sc_id;
   logic [IW-1:0]               sw_slot;

   tmh_pkg::rec_type            rbuf [2**tmh_pkg::RB_AW];
   tmh_pkg::rec_type            rb_q_ff, push_rec;
   logic                        push_en;

   logic [IW-1:0]               last_slot, parent;
   logic [LW-1:0]               lidx, ridx;
   logic                        l_ok, r_ok, do_take;
   logic [IW-1:0]               m_idx;
   tmh_pkg::entry_type          m_ent;
   logic                        m_move;

   tmh_heap_ram #(.DEPTH(CAPACITY), .AW(IW)) u_ram (
      .clock     (clock),
      .wr_en     (hw_en),
      .wr_addr   (hw_addr),
      .wr_data   (hw_data),
      .rd_addr_a (ra_addr),
      .rd_data_a (ra_data),
      .rd_addr_b (rb_addr),
      .rd_data_b (rb_data)
   );

   assign last_slot = IW'(count_ff - 7'd1);
   assign parent    = IW'((hole_ff - IW'(1)) >> 1);
   assign lidx      = {1'b0, hole_ff, 1'b1};
   assign ridx      = lidx + LW'(1);
   assign l_ok      = 32'(lidx) < 32'(count_ff);
   assign r_ok      = 32'(ridx) < 32'(count_ff);

   always_comb begin
      logic [tmh_pkg::TIME_W-1:0] minv;
      minv   = cur_ff.expiry;
      m_idx  = hole_ff;
      m_ent  = cur_ff;
      m_move = 1'b0;
      if (l_ok && (ra_data.expiry < minv)) begin
         minv   = ra_data.expiry;
         m_idx  = IW'(lidx);
         m_ent  = ra_data;
         m_move = 1'b1;
      end
      if (r_ok && (rb_data.expiry < minv)) begin
         m_idx  = IW'(ridx);
         m_ent  = rb_data;
         m_move = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      id_in    = id_ff;
      exp_in   = exp_ff;
      now_in   = now_ff;
      top_in   = top_ff;
      count_in = count_ff;
      n_in     = n_ff;
      o_in     = o_ff;
      hole_in  = hole_ff;
      loc_in   = loc_ff;
      cur_in   = cur_ff;
      hw_en    = 1'b0;
      hw_addr  = hole_ff;
      hw_data  = cur_ff;
      ra_addr  = '0;
      rb_addr  = last_slot;
      sw_en    = 1'b0;
      sw_id    = cur_ff.owner;
      sw_slot  = hole_ff;
      sv_en    = 1'b0;
      sc_en    = 1'b0;
      sc_id    = ra_data.owner;
      push_en  = 1'b0;
      push_rec = '{status: tmh_pkg::ST_ABSENT, id: '0, expiry: '0};
      do_take  = 1'b0;

      case (state_ff)
         tmh_pkg::S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               id_in    = req_tdata[5:0];
               exp_in   = req_tdata[37:6];
               now_in   = req_tdata[69:38];
               n_in     = '0;
               state_in = tmh_pkg::S_LOOKUP;
            end
         end
         tmh_pkg::S_LOOKUP: begin
            case (kind_ff)
               tmh_pkg::KIND_INSERT: begin
                  state_in = tmh_pkg::S_FIN_RD;
                  push_en  = 1'b1;
                  push_rec = '{status: tmh_pkg::ST_DUP, id: id_ff, expiry: exp_ff};
                  if (!valid_q_ff) begin
                     if (32'(count_ff) >= 32'(CAPACITY)) begin
                        push_rec.status = tmh_pkg::ST_FULL;
                     end else begin
                        push_rec.status = tmh_pkg::ST_DONE;
                        cur_in   = '{owner: id_ff, expiry: exp_ff};
                        hole_in  = IW'(count_ff);
                        count_in = count_ff + 7'd1;
                        state_in = tmh_pkg::S_UP;
                     end
                  end
               end
               tmh_pkg::KIND_REMOVE, tmh_pkg::KIND_ADJUST: begin
                  push_en = 1'b1;
                  if (!valid_q_ff) begin
                     push_rec = '{status: tmh_pkg::ST_ABSENT, id: id_ff, expiry: '0};
                     state_in = tmh_pkg::S_FIN_RD;
                  end else if (kind_ff == tmh_pkg::KIND_REMOVE) begin
                     push_en  = 1'b0;
                     loc_in   = slot_q_ff;
                     ra_addr  = slot_q_ff;
                     state_in = tmh_pkg::S_TAKE;
                  end else begin
                     push_rec = '{status: tmh_pkg::ST_DONE, id: id_ff, expiry: exp_ff};
                     cur_in   = '{owner: id_ff, expiry: exp_ff};
                     hole_in  = slot_q_ff;
                     state_in = tmh_pkg::S_UP;
                  end
               end
               tmh_pkg::KIND_POP: begin
                  if (count_ff == '0) begin
                     push_en  = 1'b1;
                     state_in = tmh_pkg::S_FIN_RD;
                  end else begin
                     loc_in   = '0;
                     state_in = tmh_pkg::S_TAKE;
                  end
               end
               tmh_pkg::KIND_TICK: begin
                  state_in = tmh_pkg::S_TICK_CHK;
               end
               default: begin
                  push_en  = 1'b1;
                  state_in = tmh_pkg::S_FIN_RD;
               end
            endcase
         end
         tmh_pkg::S_TAKE: begin
            do_take = 1'b1;
         end
         tmh_pkg::S_TICK_CHK: begin
            if (count_ff == '0) begin
               state_in = tmh_pkg::S_TICK_END;
            end else begin
               loc_in   = '0;
               state_in = tmh_pkg::S_TICK_EVAL;
            end
         end
         tmh_pkg::S_TICK_EVAL: begin
            if (ra_data.expiry <= now_ff) begin
               do_take = 1'b1;
            end else begin
               state_in = tmh_pkg::S_TICK_END;
            end
         end
         tmh_pkg::S_TICK_END: begin
            if (n_ff == '0) begin
               push_en  = 1'b1;
               push_rec = '{status: tmh_pkg::ST_NONE, id: '0, expiry: '0};
            end
            state_in = tmh_pkg::S_FIN_RD;
         end
         tmh_pkg::S_UP: begin
            ra_addr = parent;
            if (hole_ff == '0) begin
               state_in = tmh_pkg::S_DN;
            end else begin
               state_in = tmh_pkg::S_UP_CMP;
            end
         end
         tmh_pkg::S_UP_CMP: begin
            if (ra_data.expiry > cur_ff.expiry) begin
               hw_en    = 1'b1;
               hw_data  = ra_data;
               sw_en    = 1'b1;
               sw_id    = ra_data.owner;
               hole_in  = parent;
               state_in = tmh_pkg::S_UP;
            end else begin
               state_in = tmh_pkg::S_DN;
            end
         end
         tmh_pkg::S_DN: begin
            ra_addr = IW'(lidx);
            rb_addr = IW'(ridx);
            if (l_ok) begin
               state_in = tmh_pkg::S_DN_CMP;
            end else begin
               state_in = tmh_pkg::S_PLACE;
            end
         end
         tmh_pkg::S_DN_CMP: begin
            if (m_move) begin
               hw_en    = 1'b1;
               hw_data  = m_ent;
               sw_en    = 1'b1;
               sw_id    = m_ent.owner;
               hole_in  = m_idx;
               state_in = tmh_pkg::S_DN;
            end else begin
               state_in = tmh_pkg::S_PLACE;
            end
         end
         tmh_pkg::S_PLACE: begin
            hw_en = 1'b1;
            sw_en = 1'b1;
            sv_en = 1'b1;
            if (kind_ff == tmh_pkg::KIND_TICK) begin
               state_in = tmh_pkg::S_TICK_CHK;
            end else begin
               state_in = tmh_pkg::S_FIN_RD;
            end
         end
         tmh_pkg::S_FIN_RD: begin
            state_in = tmh_pkg::S_FIN;
         end
         tmh_pkg::S_FIN: begin
            top_in   = (count_ff != '0) ? ra_data.expiry : '0;
            o_in     = '0;
            state_in = tmh_pkg::S_OUT_RD;
         end
         tmh_pkg::S_OUT_RD: begin
            state_in = tmh_pkg::S_OUT;
         end
         tmh_pkg::S_OUT: begin
            if (rsp_tready) begin
               if (o_ff == n_ff - 7'd1) begin
                  state_in = tmh_pkg::S_IDLE;
               end else begin
                  o_in     = o_ff + 7'd1;
                  state_in = tmh_pkg::S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = tmh_pkg::S_IDLE;
         end
      endcase

      if (do_take) begin
         push_en  = 1'b1;
         push_rec = '{status: tmh_pkg::ST_DONE, id: ra_data.owner, expiry: ra_data.expiry};
         if (kind_ff == tmh_pkg::KIND_TICK) begin
            push_rec.status = tmh_pkg::ST_EXPIRED;
         end
         sc_en    = 1'b1;
         count_in = count_ff - 7'd1;
         if (loc_ff == last_slot) begin
            if (kind_ff == tmh_pkg::KIND_TICK) begin
               state_in = tmh_pkg::S_TICK_CHK;
            end else begin
               state_in = tmh_pkg::S_FIN_RD;
            end
         end else begin
            cur_in   = rb_data;
            hole_in  = loc_ff;
            state_in = tmh_pkg::S_UP;
         end
      end

      if (push_en) begin
         n_in = n_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmh_pkg::S_IDLE;
         count_ff <= '0;
         n_ff     <= '0;
         o_ff     <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         n_ff     <= n_in;
         o_ff     <= o_in;
         if (sc_en) begin
            valid_ff[sc_id] <= 1'b0;
         end
         if (sv_en) begin
            valid_ff[cur_ff.owner] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      id_ff      <= id_in;
      exp_ff     <= exp_in;
      now_ff     <= now_in;
      top_ff     <= top_in;
      hole_ff    <= hole_in;
      loc_ff     <= loc_in;
      cur_ff     <= cur_in;
      if (sw_en) begin
         slot_mem[sw_id] <= sw_slot;
      end
      slot_q_ff  <= slot_mem[req_tdata[5:0]];
      valid_q_ff <= valid_ff[req_tdata[5:0]];
      if (push_en) begin
         rbuf[n_ff[tmh_pkg::RB_AW-1:0]] <= push_rec;
      end
      rb_q_ff <= rbuf[o_ff[tmh_pkg::RB_AW-1:0]];
   end

   assign req_tready = (state_ff == tmh_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == tmh_pkg::S_OUT);
   assign rsp_tuser  = rb_q_ff.status;
   assign rsp_tlast  = (o_ff == n_ff - 7'd1);
   assign rsp_tdata  = {2'b00, top_ff, (count_ff != '0), count_ff,
                        rb_q_ff.expiry, rb_q_ff.id};

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Timer min-heap unit testbench
// Drives insert, remove, adjust, pop, tick and unused-kind transfers into the
// timer heap, predicts every response with a behavioral heap of its own, and
// checks each response field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 64;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  id;
      logic [31:0] expiry;
      logic        last;
      logic [6:0]  count;
      logic        top_valid;
      logic [31:0] top_expire;
   } resp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic [79:0] rsp_tdata;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned failures = 0;

   resp_type    pending_q[$];
   resp_type    batch[$];
   logic [31:0] hp_exp[CAP];
   logic [5:0]  hp_own[CAP];
   int          slot_map[64];
   int          held;

   timer_min_heap_unit #(.CAPACITY(CAP)) u_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL timer_min_heap_unit");
      $finish;
   end

   function automatic void swap_slots(int a, int b);
      logic [31:0] e;
      logic [5:0]  o;
      e = hp_exp[a]; o = hp_own[a];
      hp_exp[a] = hp_exp[b]; hp_own[a] = hp_own[b];
      hp_exp[b] = e; hp_own[b] = o;
      slot_map[hp_own[a]] = a;
      slot_map[hp_own[b]] = b;
   endfunction

   function automatic void sift_up(int h);
      int p;
      while (h > 0) begin
         p = (h - 1) / 2;
         if (hp_exp[p] <= hp_exp[h]) break;
         swap_slots(p, h);
         h = p;
      end
   endfunction

   function automatic void sift_down(int h);
      int l, r, m;
      forever begin
         l = 2 * h + 1; r = 2 * h + 2; m = h;
         if (l < held && hp_exp[l] < hp_exp[m]) m = l;
         if (r < held && hp_exp[r] < hp_exp[m]) m = r;
         if (m == h) break;
         swap_slots(m, h);
         h = m;
      end
   endfunction

   function automatic void take_slot(int loc);
      int lp;
      logic [5:0] moved;
      lp = held - 1;
      slot_map[hp_own[loc]] = CAP;
      held = lp;
      if (loc != lp) begin
         moved = hp_own[lp];
         hp_exp[loc] = hp_exp[lp];
         hp_own[loc] = moved;
         slot_map[moved] = loc;
         sift_up(loc);
         sift_down(slot_map[moved]);
      end
   endfunction

   function automatic void add_resp(logic [2:0] st, logic [5:0] id, logic [31:0] ex,
                                    logic last);
      resp_type r;
      r = '0;
      r.status = st; r.id = id; r.expiry = ex; r.last = last;
      batch.push_back(r);
   endfunction

   function automatic void predict_timer_step(logic [2:0] kind, logic [5:0] id,
                                              logic [31:0] ex, logic [31:0] now);
      int loc;
      logic [31:0] old;
      resp_type r;
      batch.delete();
      case (kind)
         tmh_pkg::KIND_INSERT: begin
            if (slot_map[id] < held) add_resp(tmh_pkg::ST_DUP, id, ex, 1'b1);
            else if (held >= CAP) add_resp(tmh_pkg::ST_FULL, id, ex, 1'b1);
            else begin
               hp_exp[held] = ex; hp_own[held] = id; slot_map[id] = held;
               held++;
               sift_up(held - 1);
               add_resp(tmh_pkg::ST_DONE, id, ex, 1'b1);
            end
         end
         tmh_pkg::KIND_REMOVE, tmh_pkg::KIND_ADJUST: begin
            loc = slot_map[id];
            if (loc >= held) add_resp(tmh_pkg::ST_ABSENT, id, '0, 1'b1);
            else if (kind == tmh_pkg::KIND_REMOVE) begin
               old = hp_exp[loc];
               take_slot(loc);
               add_resp(tmh_pkg::ST_DONE, id, old, 1'b1);
            end else begin
               hp_exp[loc] = ex;
               sift_up(loc);
               sift_down(slot_map[id]);
               add_resp(tmh_pkg::ST_DONE, id, ex, 1'b1);
            end
         end
         tmh_pkg::KIND_POP: begin
            if (held == 0) add_resp(tmh_pkg::ST_ABSENT, '0, '0, 1'b1);
            else begin
               add_resp(tmh_pkg::ST_DONE, hp_own[0], hp_exp[0], 1'b1);
               take_slot(0);
            end
         end
         tmh_pkg::KIND_TICK: begin
            while (held > 0 && hp_exp[0] <= now && batch.size() < 64) begin
               add_resp(tmh_pkg::ST_EXPIRED, hp_own[0], hp_exp[0], 1'b0);
               take_slot(0);
            end
            if (batch.size() == 0) add_resp(tmh_pkg::ST_NONE, '0, '0, 1'b1);
            else batch[batch.size() - 1].last = 1'b1;
         end
         default: add_resp(tmh_pkg::ST_ABSENT, '0, '0, 1'b1);
      endcase
      foreach (batch[k]) begin
         r = batch[k];
         r.count = 7'(held);
         r.top_valid = held > 0;
         r.top_expire = held > 0 ? hp_exp[0] : '0;
         pending_q.push_back(r);
      end
   endfunction

   task automatic send_item(logic [2:0] kind, logic [5:0] id, logic [31:0] ex,
                            logic [31:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b0, now, ex, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_timer_step(kind, id, ex, now);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      resp_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $error("unexpected response status=%0d", rsp_tuser);
            failures++;
         end else begin
            exp_r = pending_q.pop_front();
            if (rsp_tuser !== exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_tuser); failures++;
            end
            if (rsp_tdata[5:0] !== exp_r.id) begin
               $error("out_timer_id exp %0d got %0d", exp_r.id, rsp_tdata[5:0]);
               failures++;
            end
            if (rsp_tdata[37:6] !== exp_r.expiry) begin
               $error("out_expire exp %0h got %0h", exp_r.expiry, rsp_tdata[37:6]);
               failures++;
            end
            if (rsp_tlast !== exp_r.last) begin
               $error("last exp %0d got %0d", exp_r.last, rsp_tlast); failures++;
            end
            if (rsp_tdata[44:38] !== exp_r.count) begin
               $error("count exp %0d got %0d", exp_r.count, rsp_tdata[44:38]);
               failures++;
            end
            if (rsp_tdata[45] !== exp_r.top_valid) begin
               $error("top_valid exp %0d got %0d", exp_r.top_valid, rsp_tdata[45]);
               failures++;
            end
            if (rsp_tdata[77:46] !== exp_r.top_expire) begin
               $error("top_expire exp %0h got %0h", exp_r.top_expire, rsp_tdata[77:46]);
               failures++;
            end
         end
      end
   end

   function automatic logic [5:0] rand_id();
      return 6'($urandom_range(63));
   endfunction

   task automatic test_directed();
      send_item(tmh_pkg::KIND_POP, 6'd0, 32'd0, 32'd0);
      send_item(tmh_pkg::KIND_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
      send_item(tmh_pkg::KIND_REMOVE, 6'd63, 32'd0, 32'd0);
      send_item(tmh_pkg::KIND_ADJUST, 6'd5, 32'd9, 32'd0);
      send_item(tmh_pkg::KIND_INSERT, 6'd0, 32'hFFFF_FFFF, 32'd0);
      send_item(tmh_pkg::KIND_INSERT, 6'd63, 32'd0, 32'd0);
      send_item(tmh_pkg::KIND_INSERT, 6'd63, 32'd7, 32'd0);
      send_item(tmh_pkg::KIND_INSERT, 6'd21, 32'd100, 32'd0);
      send_item(tmh_pkg::KIND_INSERT, 6'd42, 32'd100, 32'd0);
      send_item(tmh_pkg::KIND_INSERT, 6'd7, 32'd50, 32'd0);
      send_item(tmh_pkg::KIND_ADJUST, 6'd0, 32'd1, 32'd0);
      send_item(tmh_pkg::KIND_ADJUST, 6'd63, 32'd200, 32'd0);
      send_item(tmh_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0);
      send_item(tmh_pkg::KIND_TICK, 6'd0, 32'd0, 32'd100);
      send_item(tmh_pkg::KIND_REMOVE, 6'd63, 32'd0, 32'd0);
      send_item(3'd5, 6'd0, 32'd0, 32'd0);
      send_item(3'd6, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(3'd7, 6'd1, 32'd3, 32'd3);
      send_item(tmh_pkg::KIND_POP, 6'd0, 32'd0, 32'd0);
      send_item(tmh_pkg::KIND_POP, 6'd0, 32'd0, 32'd0);
   endtask

   task automatic test_full_heap();
      for (int i = 0; i < 64; i++)
         send_item(tmh_pkg::KIND_INSERT, i[5:0], $urandom_range(1000), 32'd0);
      send_item(tmh_pkg::KIND_INSERT, 6'd3, 32'd5, 32'd0);
      drain();
      send_item(tmh_pkg::KIND_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
   endtask

   task automatic test_random(int n);
      logic [2:0]  kind;
      logic [31:0] ex;
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 40) kind = tmh_pkg::KIND_INSERT;
         else if (sel < 55) kind = tmh_pkg::KIND_REMOVE;
         else if (sel < 70) kind = tmh_pkg::KIND_ADJUST;
         else if (sel < 80) kind = tmh_pkg::KIND_POP;
         else if (sel < 96) kind = tmh_pkg::KIND_TICK;
         else kind = 3'($urandom_range(7, 5));
         ex = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(2000));
         send_item(kind, rand_id(), ex,
                   ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(1500)));
      end
   endtask

   initial begin
      for (int i = 0; i < 64; i++) slot_map[i] = CAP;
      held = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_heap();
      drain();
      test_random(100);
      send_idle_pct = 86;
      test_random(80);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 86;
      test_random(80);
      send_idle_pct = 23;
      recv_stall_pct = 23;
      test_random(90);
      drain();
      if (failures == 0) begin
         $display("PASS timer_min_heap_unit");
      end else begin
         $display("FAIL timer_min_heap_unit");
      end
      $finish;
   end

endmodule
